@@ rtl/csu_pkg.sv @@
// shared types, constants and register map of the coordinate scaling unit
// no dependencies; imported by every module of the unit
`default_nettype none

package csu_pkg;

  // field widths
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned DIV_W       = 32;
  localparam int unsigned DVS_W       = 31;
  localparam int unsigned PIXEL_SHIFT = 12;
  localparam int unsigned ADDR_W      = 5;

  // pipeline layout: operand prep, one divider cell per quotient bit, output stage
  localparam int unsigned PREP_STAGES = 3;
  localparam int unsigned DIV_STEPS   = DIV_W;
  localparam int unsigned NUM_STAGES  = PREP_STAGES + DIV_STEPS + 1;

  // request types
  localparam logic [1:0] OP_TO_PIXEL = 2'd0;
  localparam logic [1:0] OP_REMAP    = 2'd1;
  localparam logic [1:0] OP_QUOTIENT = 2'd2;

  // register indexes (byte address is 4 times the index)
  localparam logic [2:0] REG_HALF_PIXEL     = 3'd0;
  localparam logic [2:0] REG_PIXEL_SIZE     = 3'd1;
  localparam logic [2:0] REG_ORIGIN_OLD     = 3'd2;
  localparam logic [2:0] REG_SCALE_NUM      = 3'd3;
  localparam logic [2:0] REG_HALF_SCALE_DEN = 3'd4;
  localparam logic [2:0] REG_SCALE_DEN      = 3'd5;
  localparam logic [2:0] REG_ORIGIN_NEW     = 3'd6;

  typedef struct packed {
    logic [31:0]        half_pixel;
    logic [DVS_W-1:0]   pixel_size;
    logic [15:0]        origin_old;
    logic [15:0]        scale_num;
    logic [31:0]        half_scale_den;
    logic [14:0]        scale_den;
    logic [15:0]        origin_new;
  } cfg_t;

  // operands on their way into the divider
  typedef struct packed {
    logic [1:0]         op;
    logic [DIV_W-1:0]   val;
    logic [DVS_W-1:0]   dvs;
    logic               dz;
    logic               kill;
    logic               q_neg;
    logic               mul_pos;
  } prep_t;

  // one item travelling down the divider chain
  typedef struct packed {
    logic [2*DIV_W-1:0] rq;
    logic [DVS_W-1:0]   dvs;
    logic [1:0]         op;
    logic               dz;
    logic               kill;
    logic               neg_q;
    logic               neg_r;
    logic               mul_pos;
  } div_item_t;

endpackage

`default_nettype wire

@@ rtl/csu_prep.sv @@
// operand preparation: product, rounding offset, sign and magnitude
// depends on csu_pkg; feeds the first divider cell
`default_nettype none

module csu_prep (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire csu_pkg::cfg_t               cfg_i,
  input  wire logic [csu_pkg::PREP_STAGES-1:0] ld_i,
  input  wire logic                        valid_i,
  input  wire logic [1:0]                  op_i,
  input  wire logic [15:0]                 value_i,
  input  wire logic [15:0]                 multiplier_i,
  input  wire logic [15:0]                 divisor_i,
  output logic [csu_pkg::PREP_STAGES-1:0]  valid_o,
  output csu_pkg::div_item_t               item_o
);
  import csu_pkg::*;

  logic [PREP_STAGES-1:0] valid_d, valid_q;
  prep_t                  a_d, a_q, b_d, b_q;
  div_item_t              c_d, c_q;

  logic signed [16:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [32:0] prod;
  logic [15:0]        q_mag;
  logic [31:0]        addend;

  // multiplier operands: offset value and scale for remap, raw factors otherwise
  assign mul_a = (op_i == OP_REMAP) ?
                 17'($signed(value_i)) - 17'($signed(cfg_i.origin_old)) :
                 17'($signed(value_i));
  assign mul_b = (op_i == OP_REMAP) ? $signed(cfg_i.scale_num) : $signed(multiplier_i);

  // stage a: shared multiplier, divisor select and zero check
  assign prod  = mul_a * mul_b;
  assign q_mag = divisor_i[15] ? 16'(16'd0 - divisor_i) : divisor_i;

  always_comb begin
    a_d     = '0;
    a_d.op  = op_i;
    case (op_i)
      OP_TO_PIXEL: begin
        a_d.val = {{(DIV_W-COORD_W-PIXEL_SHIFT){value_i[15]}}, value_i, PIXEL_SHIFT'(0)};
        a_d.dvs = cfg_i.pixel_size;
        a_d.dz  = (cfg_i.pixel_size == '0);
      end
      OP_REMAP: begin
        a_d.val = prod[DIV_W-1:0];
        a_d.dvs = DVS_W'(cfg_i.scale_den);
        a_d.dz  = (cfg_i.scale_den == '0);
      end
      OP_QUOTIENT: begin
        a_d.val     = prod[DIV_W-1:0];
        a_d.dvs     = DVS_W'(q_mag);
        a_d.dz      = (divisor_i == '0);
        a_d.q_neg   = divisor_i[15];
        a_d.mul_pos = !multiplier_i[15] && (multiplier_i != '0);
      end
      default: begin
        a_d.val = '0;
      end
    endcase
    a_d.kill = a_d.dz || (op_i != OP_TO_PIXEL && op_i != OP_REMAP && op_i != OP_QUOTIENT);
  end

  // stage b: rounding offset
  always_comb begin
    case (a_q.op)
      OP_TO_PIXEL: addend = cfg_i.half_pixel;
      OP_REMAP:    addend = cfg_i.half_scale_den;
      default:     addend = '0;
    endcase
    b_d     = a_q;
    b_d.val = a_q.val + addend;
  end

  // stage c: sign and magnitude of the dividend
  always_comb begin
    c_d         = '0;
    c_d.rq      = {DIV_W'(0), (b_q.val[DIV_W-1] ? DIV_W'(DIV_W'(0) - b_q.val) : b_q.val)};
    c_d.dvs     = b_q.dvs;
    c_d.op      = b_q.op;
    c_d.dz      = b_q.dz;
    c_d.kill    = b_q.kill;
    c_d.neg_r   = b_q.val[DIV_W-1];
    c_d.neg_q   = b_q.val[DIV_W-1] ^ b_q.q_neg;
    c_d.mul_pos = b_q.mul_pos;
  end

  // stage valid bits
  always_comb begin
    valid_d[0] = ld_i[0] ? valid_i    : valid_q[0];
    valid_d[1] = ld_i[1] ? valid_q[0] : valid_q[1];
    valid_d[2] = ld_i[2] ? valid_q[1] : valid_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      a_q <= a_d;
    end
    if (ld_i[1]) begin
      b_q <= b_d;
    end
    if (ld_i[2]) begin
      c_q <= c_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = c_q;

endmodule

`default_nettype wire

@@ rtl/csu_div_cell.sv @@
// one restoring divider cell: resolves a single quotient bit per item
// depends on csu_pkg; chained by the top level
`default_nettype none

module csu_div_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               ld_i,
  input  wire logic               valid_i,
  input  wire csu_pkg::div_item_t item_i,
  output logic                    valid_o,
  output csu_pkg::div_item_t      item_o
);
  import csu_pkg::*;

  logic                  valid_q;
  div_item_t             item_d, item_q;
  logic [2*DIV_W-1:0]    shifted;
  logic [DIV_W-1:0]      dvs_ext;

  // shift in the next dividend bit, subtract the divisor when it fits
  assign shifted = {item_i.rq[2*DIV_W-2:0], 1'b0};
  assign dvs_ext = {1'b0, item_i.dvs};

  always_comb begin
    item_d    = item_i;
    item_d.rq = shifted;
    if (shifted[2*DIV_W-1:DIV_W] >= dvs_ext) begin
      item_d.rq = {DIV_W'(shifted[2*DIV_W-1:DIV_W] - dvs_ext), shifted[DIV_W-1:1], 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ld_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ rtl/csu_post.sv @@
// result stage: quotient sign, remap offset, doubled remainder and step
// depends on csu_pkg; holds the output register of the unit
`default_nettype none

module csu_post (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               ld_i,
  input  wire logic               valid_i,
  input  wire csu_pkg::div_item_t item_i,
  input  wire logic [15:0]        origin_new_i,
  output logic                    valid_o,
  output logic [15:0]             result_o,
  output logic [15:0]             rem2_o,
  output logic [15:0]             step_o,
  output logic                    dz_o
);
  import csu_pkg::*;

  logic        valid_q;
  logic [15:0] result_d, result_q, rem2_d, rem2_q, step_d, step_q;
  logic        dz_q;
  logic [15:0] quo, x, r2, rs;

  always_comb begin
    // signed quotient wrapped to the coordinate width
    quo = item_i.rq[COORD_W-1:0];
    x   = item_i.neg_q ? 16'(16'd0 - quo) : quo;

    // doubled remainder, signed like the dividend, then absolute
    r2 = {item_i.rq[DIV_W+COORD_W-2:DIV_W], 1'b0};
    rs = item_i.neg_r ? 16'(16'd0 - r2) : r2;

    result_d = (item_i.op == OP_REMAP) ? 16'(x + origin_new_i) : x;
    rem2_d   = rs[15] ? 16'(16'd0 - rs) : rs;

    // quotient moved one away from zero; a zero quotient gives +1 only for a positive multiplier
    if (x == '0) begin
      step_d = item_i.mul_pos ? 16'd1 : 16'hFFFF;
    end else if (x[15]) begin
      step_d = 16'(x - 16'd1);
    end else begin
      step_d = 16'(x + 16'd1);
    end

    if (item_i.op != OP_QUOTIENT) begin
      rem2_d = '0;
      step_d = '0;
    end
    if (item_i.kill) begin
      result_d = '0;
      rem2_d   = '0;
      step_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ld_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      result_q <= result_d;
      rem2_q   <= rem2_d;
      step_q   <= step_d;
      dz_q     <= item_i.dz;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;
  assign rem2_o   = rem2_q;
  assign step_o   = step_q;
  assign dz_o     = dz_q;

endmodule

`default_nettype wire

@@ rtl/coordinate_scaling_unit.sv @@
// top level of the coordinate scaling unit: register port, pipeline control
// depends on csu_pkg, csu_prep, csu_div_cell and csu_post
//
//   channel   dir  handshake                 contents
//   s_axis    in   tvalid/tready             tdata value, multiplier, divisor; tuser req_type
//   m_axis    out  tvalid/tready             tdata result, twice_abs_remainder, step;
//                                            tuser div_by_zero
//   apb       in   psel/penable/pwrite       seven 32-bit registers at 4*index
//
// one request per cycle sustained while the output is not stalled; from acceptance to tvalid a request passes
// three operand stages, 32 divider cells (one quotient bit each) and the output
// register, the first operand stage loading at the accepting edge
// reset clears every stage valid bit and loads the register reset values
// a stalled output holds its result; earlier stages keep moving into empty slots,
// and s_axis_tready falls only once every stage holds a request
`default_nettype none

module coordinate_scaling_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // value[15:0], multiplier[31:16], divisor[47:32]
  input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // result[15:0], twice_abs_remainder[31:16],
                                           // step[47:32]
  output logic [0:0]       m_axis_tuser,   // div_by_zero[0]
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [csu_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import csu_pkg::*;

  cfg_t                  cfg_q;
  logic [2:0]            reg_idx;
  logic                  reg_wr;

  logic [NUM_STAGES-1:0] stg_valid;
  logic [NUM_STAGES-1:0] stg_ld;
  div_item_t             chain [DIV_STEPS+1];
  logic                  chain_valid [DIV_STEPS+1];
  logic [15:0]           res, rem2, step;
  logic                  dz;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_pixel     <= '0;
      cfg_q.pixel_size     <= DVS_W'(1);
      cfg_q.origin_old     <= '0;
      cfg_q.scale_num      <= 16'd1;
      cfg_q.half_scale_den <= '0;
      cfg_q.scale_den      <= 15'd1;
      cfg_q.origin_new     <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_HALF_PIXEL:     cfg_q.half_pixel     <= pwdata;
        REG_PIXEL_SIZE:     cfg_q.pixel_size     <= pwdata[DVS_W-1:0];
        REG_ORIGIN_OLD:     cfg_q.origin_old     <= pwdata[15:0];
        REG_SCALE_NUM:      cfg_q.scale_num      <= pwdata[15:0];
        REG_HALF_SCALE_DEN: cfg_q.half_scale_den <= pwdata;
        REG_SCALE_DEN:      cfg_q.scale_den      <= pwdata[14:0];
        REG_ORIGIN_NEW:     cfg_q.origin_new     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_HALF_PIXEL:     prdata = cfg_q.half_pixel;
      REG_PIXEL_SIZE:     prdata = 32'(cfg_q.pixel_size);
      REG_ORIGIN_OLD:     prdata = 32'(cfg_q.origin_old);
      REG_SCALE_NUM:      prdata = 32'(cfg_q.scale_num);
      REG_HALF_SCALE_DEN: prdata = cfg_q.half_scale_den;
      REG_SCALE_DEN:      prdata = 32'(cfg_q.scale_den);
      REG_ORIGIN_NEW:     prdata = 32'(cfg_q.origin_new);
      default:            prdata = '0;
    endcase
  end

  // a stage loads when it is empty or the stage after it loads
  assign stg_ld[NUM_STAGES-1] = !stg_valid[NUM_STAGES-1] || m_axis_tready;
  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_ld
    assign stg_ld[k] = !stg_valid[k] || stg_ld[k+1];
  end

  assign s_axis_tready = stg_ld[0];

  // operand preparation
  csu_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .ld_i         (stg_ld[PREP_STAGES-1:0]),
    .valid_i      (s_axis_tvalid),
    .op_i         (s_axis_tuser),
    .value_i      (s_axis_tdata[15:0]),
    .multiplier_i (s_axis_tdata[31:16]),
    .divisor_i    (s_axis_tdata[47:32]),
    .valid_o      (stg_valid[PREP_STAGES-1:0]),
    .item_o       (chain[0])
  );

  assign chain_valid[0] = stg_valid[PREP_STAGES-1];

  // divider chain, one cell per quotient bit
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
    csu_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ld_i    (stg_ld[PREP_STAGES+k]),
      .valid_i (chain_valid[k]),
      .item_i  (chain[k]),
      .valid_o (chain_valid[k+1]),
      .item_o  (chain[k+1])
    );
    assign stg_valid[PREP_STAGES+k] = chain_valid[k+1];
  end

  // result stage and output register
  csu_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ld_i         (stg_ld[NUM_STAGES-1]),
    .valid_i      (chain_valid[DIV_STEPS]),
    .item_i       (chain[DIV_STEPS]),
    .origin_new_i (cfg_q.origin_new),
    .valid_o      (stg_valid[NUM_STAGES-1]),
    .result_o     (res),
    .rem2_o       (rem2),
    .step_o       (step),
    .dz_o         (dz)
  );

  assign m_axis_tvalid = stg_valid[NUM_STAGES-1];
  assign m_axis_tdata  = {step, rem2, res};
  assign m_axis_tuser  = dz;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the coordinate scaling unit: directed and random requests
// with random idling and back-pressure, checked against an in-bench arithmetic predictor
// depends on csu_pkg and coordinate_scaling_unit
`default_nettype none

module tb;
  import csu_pkg::*;

  localparam int unsigned IDLE_PCT       = 23;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 64;   // longer than a request takes through the pipeline
  localparam logic [1:0]  OP_UNKNOWN     = 2'd3;

  // one result as it leaves the block
  typedef struct packed {
    logic [15:0] result;
    logic [15:0] rem2;
    logic [15:0] step;
    logic        dz;
  } coord_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // value[15:0], multiplier[31:16], divisor[47:32]
  logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [47:0] m_axis_tdata;        // result[15:0], twice_abs_remainder[31:16], step[47:32]
  wire  [0:0]  m_axis_tuser;        // div_by_zero[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  // register copy used by the predictor
  logic signed [31:0] half_pixel     = 32'sd0;
  logic        [30:0] pixel_size     = 31'd1;
  logic signed [15:0] origin_old     = 16'sd0;
  logic signed [15:0] scale_num      = 16'sd1;
  logic signed [31:0] half_scale_den = 32'sd0;
  logic        [14:0] scale_den      = 15'd1;
  logic signed [15:0] origin_new     = 16'sd0;

  coord_res_t  pending_q[$];
  int unsigned fail_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned settings_cnt = 0;
  int unsigned op_cnt[4] = '{0, 0, 0, 0};
  int unsigned stall_cycles = 0;
  int          hold_left = 0;
  bit          idle_en = 1'b1;

  coordinate_scaling_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // two's complement wrap helpers
  function automatic longint wrap32(longint x);
    return longint'(int'(x[31:0]));
  endfunction

  function automatic longint wrap16(longint x);
    return longint'(shortint'(x[15:0]));
  endfunction

  // expected result of one request under the current register values
  function automatic coord_res_t scale_coord(logic [1:0] op, logic signed [15:0] v,
                                             logic signed [15:0] mult,
                                             logic signed [15:0] dvs);
    coord_res_t r;
    longint t, prod, quo, rem, stp;
    r = '0;
    case (op)
      OP_TO_PIXEL: begin
        if (pixel_size == 0) begin
          r.dz = 1'b1;
        end else begin
          t = wrap32(longint'(v) * 4096 + longint'(half_pixel));
          t = t / longint'(pixel_size);
          r.result = t[15:0];
        end
      end
      OP_REMAP: begin
        if (scale_den == 0) begin
          r.dz = 1'b1;
        end else begin
          t = wrap32(longint'(v) - longint'(origin_old));
          t = wrap32(t * longint'(scale_num));
          t = wrap32(t + longint'(half_scale_den));
          t = t / longint'(scale_den);
          t = wrap32(t + longint'(origin_new));
          r.result = t[15:0];
        end
      end
      OP_QUOTIENT: begin
        if (dvs == 0) begin
          r.dz = 1'b1;
        end else begin
          prod = longint'(v) * longint'(mult);
          quo  = wrap16(prod / longint'(dvs));
          rem  = wrap16(wrap32(prod - quo * longint'(dvs)));
          rem  = wrap16(rem * 2);
          // negating the most negative doubled remainder wraps back to 0x8000
          if (rem < 0) rem = wrap16(-rem);
          if (quo > 0) stp = wrap16(quo + 1);
          else if (quo < 0) stp = wrap16(quo - 1);
          else stp = (mult > 0) ? 1 : -1;
          r.result = quo[15:0];
          r.rem2   = rem[15:0];
          r.step   = stp[15:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // random coordinate biased toward the extremes and small magnitudes
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(16)) - 16'd8;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // one register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_HALF_PIXEL:     half_pixel     = data;
      REG_PIXEL_SIZE:     pixel_size     = data[30:0];
      REG_ORIGIN_OLD:     origin_old     = data[15:0];
      REG_SCALE_NUM:      scale_num      = data[15:0];
      REG_HALF_SCALE_DEN: half_scale_den = data;
      REG_SCALE_DEN:      scale_den      = data[14:0];
      REG_ORIGIN_NEW:     origin_new     = data[15:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [31:0] hp, ps, oo, sn, hsd, sd, on);
    write_reg(REG_HALF_PIXEL, hp);
    write_reg(REG_PIXEL_SIZE, ps);
    write_reg(REG_ORIGIN_OLD, oo);
    write_reg(REG_SCALE_NUM, sn);
    write_reg(REG_HALF_SCALE_DEN, hsd);
    write_reg(REG_SCALE_DEN, sd);
    write_reg(REG_ORIGIN_NEW, on);
    settings_cnt++;
  endtask

  task automatic randomize_settings();
    logic [31:0] ps, hp, sd, hsd;
    ps  = ($urandom_range(3) == 0) ? $urandom_range(32'h7fffffff, 1)
                                   : $urandom_range(32'h10000, 1);
    hp  = $urandom_range(1) ? (ps >> 1) : $urandom;
    sd  = $urandom_range(32767, 1);
    hsd = $urandom_range(1) ? (sd >> 1) : $urandom;
    set_regs(hp, ps, $urandom, $urandom, hsd, sd, $urandom);
  endtask

  // offer one request and hold it until accepted; tvalid stays high on return
  task automatic send_req(input logic [1:0] op, input logic [15:0] v, m, d);
    if (idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d, m, v};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(scale_coord(op, v, m, d));
    op_cnt[op]++;
  endtask

  task automatic send_random_req();
    logic [1:0]  op;
    logic [15:0] dvs;
    int unsigned pick;
    pick = $urandom_range(99);
    op   = (pick < 32) ? OP_TO_PIXEL : (pick < 64) ? OP_REMAP :
           (pick < 98) ? OP_QUOTIENT : OP_UNKNOWN;
    dvs  = ($urandom_range(15) == 0) ? 16'h0000 : pick_coord();
    send_req(op, pick_coord(), pick_coord(), dvs);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // reset register values: extremes of every field, the op 2 corner cases and an unknown op
  task automatic test_defaults();
    send_req(OP_TO_PIXEL, 16'h7fff, 16'h0000, 16'h0000);
    send_req(OP_TO_PIXEL, 16'h8000, 16'hffff, 16'hffff);
    send_req(OP_REMAP,    16'h7fff, 16'h0000, 16'h0000);
    send_req(OP_REMAP,    16'h8000, 16'h0000, 16'h0000);
    // quotient wraps, step wraps in both directions
    send_req(OP_QUOTIENT, 16'h7fff, 16'h7fff, 16'h0001);
    send_req(OP_QUOTIENT, 16'h8000, 16'h0001, 16'h0001);
    send_req(OP_QUOTIENT, 16'h7fff, 16'h0001, 16'h0001);
    send_req(OP_QUOTIENT, 16'h8000, 16'h8000, 16'hffff);
    // doubled remainder hits the most negative value
    send_req(OP_QUOTIENT, 16'd16384, 16'h0001, 16'd16385);
    send_req(OP_QUOTIENT, -16'sd16384, 16'h0001, 16'd20000);
    // zero quotient, step from the sign of the multiplier
    send_req(OP_QUOTIENT, 16'h0001, 16'd5, 16'd100);
    send_req(OP_QUOTIENT, 16'h0001, 16'h0000, 16'd100);
    send_req(OP_QUOTIENT, 16'h0001, -16'sd5, 16'd100);
    send_req(OP_QUOTIENT, 16'h1234, 16'h5678, 16'h0000);
    send_req(OP_UNKNOWN,  16'hffff, 16'hffff, 16'hffff);
  endtask

  // both ends of every register range
  task automatic test_register_extremes();
    wait_results_done();
    set_regs(32'h7fffffff, 32'h7fffffff, 32'hffff8000, 32'hffff8000,
             32'h80000000, 32'd32767, 32'd32767);
    send_req(OP_TO_PIXEL, 16'h7fff, 16'h0000, 16'h0000);
    send_req(OP_REMAP,    16'h7fff, 16'h0000, 16'h0000);
    send_req(OP_REMAP,    16'h8000, 16'h0000, 16'h0000);
    wait_results_done();
    set_regs(32'h80000000, 32'd1, 32'd32767, 32'd32767,
             32'h7fffffff, 32'd1, 32'hffff8000);
    send_req(OP_TO_PIXEL, 16'h8000, 16'h0000, 16'h0000);
    send_req(OP_REMAP,    16'h8000, 16'h0000, 16'h0000);
    send_req(OP_REMAP,    16'h7fff, 16'h0000, 16'h0000);
  endtask

  // zero divisor in each operation
  task automatic test_zero_divisors();
    wait_results_done();
    set_regs(32'd100, 32'd0, 32'd0, 32'd3, 32'd0, 32'd0, 32'd0);
    send_req(OP_TO_PIXEL, 16'h0123, 16'h0000, 16'h0000);
    send_req(OP_REMAP,    16'h0123, 16'h0000, 16'h0000);
    send_req(OP_QUOTIENT, 16'h0123, 16'h0004, 16'h0000);
  endtask

  // random requests over several random settings, one phase without idling
  task automatic test_random_settings();
    for (int ph = 0; ph < 5; ph++) begin
      wait_results_done();
      randomize_settings();
      idle_en = (ph != 2);
      repeat (130) send_random_req();
    end
    idle_en = 1'b1;
  endtask

  // receiver holds off long enough to fill the pipeline while requests keep coming
  task automatic test_backpressure();
    wait_results_done();
    randomize_settings();
    idle_en   = 1'b0;
    hold_left = 200;
    repeat (150) send_random_req();
    idle_en   = 1'b1;
  endtask

  // compare one accepted result with the oldest pending expectation
  task automatic check_result();
    coord_res_t got, want;
    got.result = m_axis_tdata[15:0];
    got.rem2   = m_axis_tdata[31:16];
    got.step   = m_axis_tdata[47:32];
    got.dz     = m_axis_tuser[0];
    if (pending_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("unexpected result: result %h rem2 %h step %h dz %b",
                 got.result, got.rem2, got.step, got.dz);
    end else begin
      want = pending_q.pop_front();
      checked_cnt++;
      if (got.result !== want.result || got.rem2 !== want.rem2 ||
          got.step !== want.step || got.dz !== want.dz) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("mismatch: expected result %h rem2 %h step %h dz %b, got %h %h %h %b",
                   want.result, want.rem2, want.step, want.dz,
                   got.result, got.rem2, got.step, got.dz);
      end
    end
  endtask

  // result side: check at each accepting edge, then pick next tready
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any accepted request, result or register access
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_register_extremes();
    test_zero_divisors();
    test_random_settings();
    test_backpressure();
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      fail_cnt += pending_q.size();
      $display("%0d results never arrived", pending_q.size());
    end
    $display("covered %0d to-pixel, %0d remap, %0d quotient, %0d unknown requests",
             op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3]);
    $display("over %0d register settings; %0d results checked, %0d failures",
             settings_cnt, checked_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
